// File: hw/rtl/mtg_pkg.sv
// mtg_pkg: constants, types and the output tempering function of the
// mt19937 generator; no dependencies
package mtg_pkg;

  localparam int STATE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_DEPTH);
  localparam int WORD_W       = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [IDX_W:0]    idx_sum_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam idx_t  LAST_IDX    = idx_t'(STATE_DEPTH - 1);
  localparam word_t SEED_RESET  = 32'd5489;
  localparam word_t INIT_MULT   = 32'd1812433253;
  localparam word_t MATRIX_TERM = 32'h9908b0df;
  localparam word_t TEMPER_B    = 32'h9d2c5680;
  localparam word_t TEMPER_C    = 32'hefc60000;

  typedef enum logic [1:0] {
    S_FILL,
    S_IDLE,
    S_CALC
  } state_t;

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: hw/rtl/mtg_ram.sv
// mtg_ram: generic synchronous ram, one write port, two read ports,
// registered read; no dependencies
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: hw/rtl/mersenne_twister_generator.sv
// mersenne_twister_generator: mt19937 top level, state words in mtg_ram
// depends on mtg_pkg and mtg_ram
//
// usage:
//   in channel (in_valid/in_ready/in_request): one beat asks for one word.
//   a beat with in_request low is taken and gives no result.
//   out channel (out_valid/out_ready/out_random_word): one tempered word
//   per request beat, in order, from an output register.
//   cfg_write_en/cfg_seed: writing the seed refills the 624-word state and
//   restarts the sequence; write only while the block is idle.
// fill and request:
//   after reset or a seed write, a fill pass writes all 624 state words, one
//   a cycle, with in_ready low; reset fills from seed 5489.
//   a request then reads the next and the far state word over the two ram
//   read ports in the idle state that takes the beat, then twists, writes
//   back and loads the output register in the calc state, with in_ready low.
// stall:
//   a request beat is taken while the previous word waits on out_ready;
//   its result is held back until the output register frees up.
module mersenne_twister_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_request,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_random_word,
  input  logic                 cfg_write_en,
  input  logic [31:0]          cfg_seed
);

  mtg_pkg::state_t state_r, state_nxt;
  mtg_pkg::idx_t   fill_idx_r, fill_idx_nxt;
  mtg_pkg::word_t  fill_word_r, fill_word_nxt;
  mtg_pkg::idx_t   word_idx_r, word_idx_nxt;
  mtg_pkg::word_t  cur_word_r, cur_word_nxt;
  logic            out_valid_r, out_valid_nxt;
  mtg_pkg::word_t  out_word_r, out_word_nxt;

  logic            ram_we;
  mtg_pkg::idx_t   ram_waddr;
  mtg_pkg::word_t  ram_wdata;
  mtg_pkg::word_t  rdata_a;
  mtg_pkg::word_t  rdata_b;

  mtg_pkg::idx_t    next_idx;
  mtg_pkg::idx_sum_t far_sum;
  mtg_pkg::idx_sum_t far_wrap;
  mtg_pkg::idx_t    far_idx;
  mtg_pkg::idx_t    fill_idx_inc;
  mtg_pkg::word_t   fill_mix;
  mtg_pkg::word_t   fill_prod;
  mtg_pkg::word_t   mix_y;
  mtg_pkg::word_t   twist_word;

  // read addresses for the word after the current one and the far word
  assign next_idx = (word_idx_r == mtg_pkg::LAST_IDX) ? '0 : word_idx_r + 1'b1;
  assign far_sum  = {1'b0, word_idx_r} + mtg_pkg::idx_sum_t'(mtg_pkg::TWIST_OFFSET);
  assign far_wrap = far_sum - mtg_pkg::idx_sum_t'(mtg_pkg::STATE_DEPTH);
  assign far_idx  = (far_sum >= mtg_pkg::idx_sum_t'(mtg_pkg::STATE_DEPTH)) ?
                    far_wrap[mtg_pkg::IDX_W-1:0] : far_sum[mtg_pkg::IDX_W-1:0];

  // seed recurrence
  assign fill_idx_inc = fill_idx_r + 1'b1;
  assign fill_mix     = fill_word_r ^ (fill_word_r >> 30);
  assign fill_prod    = mtg_pkg::INIT_MULT * fill_mix;

  // twist of one word
  assign mix_y      = {cur_word_r[31], rdata_a[30:0]};
  assign twist_word = rdata_b ^ {1'b0, mix_y[31:1]} ^
                      (mix_y[0] ? mtg_pkg::MATRIX_TERM : '0);

  mtg_ram #(
    .WIDTH (mtg_pkg::WORD_W),
    .DEPTH (mtg_pkg::STATE_DEPTH)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (next_idx),
    .raddr_b (far_idx),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtg_pkg::S_FILL;
      fill_idx_r  <= '0;
      fill_word_r <= mtg_pkg::SEED_RESET;
      word_idx_r  <= '0;
      cur_word_r  <= mtg_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_idx_r  <= fill_idx_nxt;
      fill_word_r <= fill_word_nxt;
      word_idx_r  <= word_idx_nxt;
      cur_word_r  <= cur_word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_idx_nxt  = fill_idx_r;
    fill_word_nxt = fill_word_r;
    word_idx_nxt  = word_idx_r;
    cur_word_nxt  = cur_word_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = word_idx_r;
    ram_wdata     = twist_word;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mtg_pkg::S_FILL: begin
        ram_we        = 1'b1;
        ram_waddr     = fill_idx_r;
        ram_wdata     = fill_word_r;
        fill_idx_nxt  = fill_idx_inc;
        fill_word_nxt = fill_prod +
                        {{(mtg_pkg::WORD_W - mtg_pkg::IDX_W){1'b0}}, fill_idx_inc};
        if (fill_idx_r == mtg_pkg::LAST_IDX) begin
          fill_idx_nxt = '0;
          state_nxt    = mtg_pkg::S_IDLE;
        end
      end
      mtg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_request) begin
          state_nxt = mtg_pkg::S_CALC;
        end
      end
      mtg_pkg::S_CALC: begin
        if (!out_valid_r || out_ready) begin
          ram_we        = 1'b1;
          cur_word_nxt  = rdata_a;
          word_idx_nxt  = next_idx;
          out_valid_nxt = 1'b1;
          out_word_nxt  = mtg_pkg::temper(twist_word);
          state_nxt     = mtg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtg_pkg::S_FILL;
      end
    endcase

    // seed write restarts the fill pass
    if (cfg_write_en) begin
      state_nxt     = mtg_pkg::S_FILL;
      fill_idx_nxt  = '0;
      fill_word_nxt = cfg_seed;
      cur_word_nxt  = cfg_seed;
      word_idx_nxt  = '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write_en |=> (state_r == mtg_pkg::S_FILL && fill_idx_r == '0 && !in_ready))
    else $error("seed write did not restart the fill");

  a_addr_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtg_pkg::S_CALC) |-> (far_idx != word_idx_r && next_idx != word_idx_r))
    else $error("read address collides with write address");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtg_pkg::S_CALC && out_valid_r && !out_ready && !cfg_write_en)
    |=> (state_r == mtg_pkg::S_CALC && $stable(word_idx_r) && $stable(out_word_r)))
    else $error("result overwritten while output stalled");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtg_pkg::S_CALC && (!out_valid_r || out_ready) && !cfg_write_en)
    |=> (out_valid_r && word_idx_r == $past(next_idx) && state_r == mtg_pkg::S_IDLE))
    else $error("word index or output did not advance");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (word_idx_r <= mtg_pkg::LAST_IDX && fill_idx_r <= mtg_pkg::LAST_IDX))
    else $error("index beyond state depth");

endmodule
